[hw/rtl/timer_slot_scheduler_defines.svh]
// Assertion macros shared by the timer slot scheduler RTL
`ifndef TIMER_SLOT_SCHEDULER_DEFINES_SVH
`define TIMER_SLOT_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define TSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true outside reset
`define TSS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define TSS_ASSERT(lbl, clk, rst_n, prop, msg)

`define TSS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[hw/rtl/tss_pkg.sv]
// Shared constants and types of the timer slot scheduler
package tss_pkg;

    localparam int NUM_SLOTS_DEF  = 16;
    localparam int TIME_BITS_DEF  = 32;
    localparam int MAX_RESULTS    = 16;

    localparam int KIND_W         = 2;
    localparam int ID_W           = 16;
    localparam int DLY_W          = 20;
    localparam int IVL_W          = 20;
    localparam int CFG_W          = 5;
    localparam int ACT_W          = 5;
    localparam int FIRE_W         = 32;

    localparam logic [CFG_W-1:0]  MAX_ACTIVE_RST = 5'd16;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic clear;
        logic load;
    } scan_ctl_t;

    // what one pass over the slot table found
    typedef struct packed {
        logic best_found;
        logic match_found;
        logic free_found;
    } scan_flags_t;

endpackage

[hw/rtl/timer_slot_scheduler.sv]
// Timer slot scheduler top level: sequencer, slot table and state counters
//
//  channel   | handshake                | payload
//  ----------+--------------------------+-----------------------------------------------
//  command   | start / busy             | kind, delay_ticks, interval_ticks, periodic,
//            |                          | target_id
//  config    | cfg_valid / cfg_ready    | cfg_data (max_active)
//  result    | reply_valid (strobe)     | reply_kind, reply_id, ok, active_count,
//            |                          | fired_total, last
//
//  A pass over the slot table reads one slot per cycle into a two-stage compare unit,
//  then acts in the finish state. Add and cancel take one pass; a tick takes one pass
//  per fired timer plus one, or 16 passes and a flush state when 16 fire. An add or cancel
//  result shows the cycle after its pass, a fire event one pass later; busy drops with
//  the final result and the receiver cannot stall. Reset clears the valid bits at once;
//  no clearing pass is needed.
module timer_slot_scheduler #(
    parameter int NUM_SLOTS = tss_pkg::NUM_SLOTS_DEF,
    parameter int TIME_BITS = tss_pkg::TIME_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tss_pkg::KIND_W-1:0]  kind,
    input  logic [tss_pkg::DLY_W-1:0]   delay_ticks,
    input  logic [tss_pkg::IVL_W-1:0]   interval_ticks,
    input  logic                        periodic,
    input  logic [tss_pkg::ID_W-1:0]    target_id,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tss_pkg::CFG_W-1:0]   cfg_data,
    output logic                        reply_valid,
    output logic [tss_pkg::KIND_W-1:0]  reply_kind,
    output logic [tss_pkg::ID_W-1:0]    reply_id,
    output logic                        ok,
    output logic [tss_pkg::ACT_W-1:0]   active_count,
    output logic [tss_pkg::FIRE_W-1:0]  fired_total,
    output logic                        last
);

    `include "timer_slot_scheduler_defines.svh"

    localparam int IDX_W  = $clog2(NUM_SLOTS);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int SCAN_W = $clog2(NUM_SLOTS + 2);
    localparam int LIM_W  = (CNT_W > tss_pkg::CFG_W) ? CNT_W : tss_pkg::CFG_W;
    localparam int RES_W  = $clog2(tss_pkg::MAX_RESULTS + 1);
    localparam int IVL_LO = TIME_BITS;
    localparam int PER_B  = TIME_BITS + tss_pkg::IVL_W;
    localparam int ID_LO  = TIME_BITS + tss_pkg::IVL_W + 1;
    localparam int WORD_W = ID_LO + tss_pkg::ID_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;
    localparam logic [1:0] S_FLUSH  = 2'd3;

    // control state
    logic [1:0]                   state_reg, state_next;
    logic [SCAN_W-1:0]            cnt_reg, cnt_next;
    logic [tss_pkg::KIND_W-1:0]   op_reg, op_next;
    logic [TIME_BITS-1:0]         now_reg, now_next;
    logic [tss_pkg::ID_W-1:0]     next_id_reg, next_id_next;
    logic [tss_pkg::FIRE_W-1:0]   fire_reg, fire_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [NUM_SLOTS-1:0]         valid_reg, valid_next;
    logic [NUM_SLOTS-1:0]         done_reg, done_next;
    logic [tss_pkg::CFG_W-1:0]    max_active_reg, max_active_next;
    logic [RES_W-1:0]             nres_reg, nres_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic                         rd_valid_reg, rd_valid_next;
    logic                         reply_valid_reg, reply_valid_next;

    // payload
    logic [tss_pkg::ID_W-1:0]     key_reg, key_next;
    logic [tss_pkg::DLY_W-1:0]    delay_reg, delay_next;
    logic [tss_pkg::IVL_W-1:0]    interval_reg, interval_next;
    logic                         periodic_reg, periodic_next;
    logic [tss_pkg::ID_W-1:0]     pend_id_reg, pend_id_next;
    logic [CNT_W-1:0]             pend_count_reg, pend_count_next;
    logic [tss_pkg::FIRE_W-1:0]   pend_fire_reg, pend_fire_next;
    logic [IDX_W-1:0]             rd_idx_reg, rd_idx_next;
    logic [tss_pkg::KIND_W-1:0]   reply_kind_reg, reply_kind_next;
    logic [tss_pkg::ID_W-1:0]     reply_id_reg, reply_id_next;
    logic                         ok_reg, ok_next;
    logic [CNT_W-1:0]             reply_count_reg, reply_count_next;
    logic [tss_pkg::FIRE_W-1:0]   reply_fire_reg, reply_fire_next;
    logic                         reply_last_reg, reply_last_next;

    // slot table and compare unit
    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [WORD_W-1:0]            ram_wdata;
    logic [IDX_W-1:0]             ram_raddr;
    logic [WORD_W-1:0]            ram_rdata;
    logic                         issue;
    tss_pkg::scan_ctl_t           scan_ctl;
    tss_pkg::scan_flags_t         scan_flags;
    logic [IDX_W-1:0]             best_idx;
    logic [tss_pkg::ID_W-1:0]     best_ident;
    logic                         best_periodic;
    logic [tss_pkg::IVL_W-1:0]    best_interval;
    logic [IDX_W-1:0]             match_idx;
    logic [IDX_W-1:0]             free_idx;

    logic [tss_pkg::ID_W-1:0]     id_cur;
    logic                         full;
    logic [CNT_W-1:0]             cnt_after;
    logic [tss_pkg::FIRE_W-1:0]   fire_inc;

    assign issue     = (state_reg == S_SCAN) && (cnt_reg < SCAN_W'(NUM_SLOTS));
    assign ram_raddr = issue ? cnt_reg[IDX_W-1:0] : '0;

    assign scan_ctl.clear = (state_reg == S_SCAN) && (cnt_reg == '0);
    assign scan_ctl.load  = rd_valid_reg;

    assign id_cur = (next_id_reg == '0) ? tss_pkg::ID_W'(1) : next_id_reg;
    assign full   = (LIM_W'(count_reg) >= LIM_W'(max_active_reg)) ||
                    (count_reg == CNT_W'(NUM_SLOTS));

    tss_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tss_scan #(
        .NUM_SLOTS (NUM_SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (scan_ctl),
        .idx           (rd_idx_reg),
        .slot_valid    (valid_reg[rd_idx_reg]),
        .slot_done     (done_reg[rd_idx_reg]),
        .rd_ident      (ram_rdata[ID_LO +: tss_pkg::ID_W]),
        .rd_periodic   (ram_rdata[PER_B]),
        .rd_interval   (ram_rdata[IVL_LO +: tss_pkg::IVL_W]),
        .rd_deadline   (ram_rdata[TIME_BITS-1:0]),
        .now           (now_reg),
        .key           (key_reg),
        .flags         (scan_flags),
        .best_idx      (best_idx),
        .best_ident    (best_ident),
        .best_periodic (best_periodic),
        .best_interval (best_interval),
        .match_idx     (match_idx),
        .free_idx      (free_idx)
    );

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        op_next          = op_reg;
        now_next         = now_reg;
        next_id_next     = next_id_reg;
        fire_next        = fire_reg;
        count_next       = count_reg;
        valid_next       = valid_reg;
        done_next        = done_reg;
        max_active_next  = max_active_reg;
        nres_next        = nres_reg;
        pend_valid_next  = pend_valid_reg;
        rd_valid_next    = issue;
        rd_idx_next      = cnt_reg[IDX_W-1:0];
        key_next         = key_reg;
        delay_next       = delay_reg;
        interval_next    = interval_reg;
        periodic_next    = periodic_reg;
        pend_id_next     = pend_id_reg;
        pend_count_next  = pend_count_reg;
        pend_fire_next   = pend_fire_reg;
        reply_valid_next = 1'b0;
        reply_kind_next  = reply_kind_reg;
        reply_id_next    = reply_id_reg;
        ok_next          = ok_reg;
        reply_count_next = reply_count_reg;
        reply_fire_next  = reply_fire_reg;
        reply_last_next  = reply_last_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        cnt_after        = count_reg;
        fire_inc         = fire_reg + tss_pkg::FIRE_W'(1);

        if (cfg_valid)
        begin
            max_active_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next       = kind;
                    delay_next    = delay_ticks;
                    interval_next = interval_ticks;
                    periodic_next = periodic;
                    cnt_next      = '0;
                    case (kind)
                        tss_pkg::KIND_ADD:
                        begin
                            // the id is used up even when the add is refused
                            key_next     = id_cur;
                            next_id_next = id_cur + tss_pkg::ID_W'(1);
                            state_next   = S_SCAN;
                        end
                        tss_pkg::KIND_CANCEL:
                        begin
                            key_next   = target_id;
                            state_next = S_SCAN;
                        end
                        tss_pkg::KIND_TICK:
                        begin
                            now_next        = now_reg + TIME_BITS'(1);
                            done_next       = '0;
                            nres_next       = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                cnt_next = cnt_reg + SCAN_W'(1);
                if (cnt_reg == SCAN_W'(NUM_SLOTS + 1))
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                case (op_reg)
                    tss_pkg::KIND_ADD:
                    begin
                        reply_valid_next = 1'b1;
                        reply_kind_next  = tss_pkg::KIND_ADD;
                        reply_fire_next  = fire_reg;
                        reply_last_next  = 1'b1;
                        if (scan_flags.match_found || full || !scan_flags.free_found)
                        begin
                            reply_id_next    = '0;
                            ok_next          = 1'b0;
                            reply_count_next = count_reg;
                        end
                        else
                        begin
                            ram_we               = 1'b1;
                            ram_waddr            = free_idx;
                            ram_wdata            = {key_reg, periodic_reg, interval_reg,
                                                    now_reg + TIME_BITS'(delay_reg)};
                            valid_next[free_idx] = 1'b1;
                            count_next           = count_reg + CNT_W'(1);
                            reply_id_next        = key_reg;
                            ok_next              = 1'b1;
                            reply_count_next     = count_reg + CNT_W'(1);
                        end
                        state_next = S_IDLE;
                    end

                    tss_pkg::KIND_CANCEL:
                    begin
                        reply_valid_next = 1'b1;
                        reply_kind_next  = tss_pkg::KIND_CANCEL;
                        reply_fire_next  = fire_reg;
                        reply_last_next  = 1'b1;
                        if ((key_reg != '0) && scan_flags.match_found)
                        begin
                            valid_next[match_idx] = 1'b0;
                            count_next            = count_reg - CNT_W'(1);
                            reply_id_next         = key_reg;
                            ok_next               = 1'b1;
                            reply_count_next      = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            reply_id_next    = '0;
                            ok_next          = 1'b0;
                            reply_count_next = count_reg;
                        end
                        state_next = S_IDLE;
                    end

                    tss_pkg::KIND_TICK:
                    begin
                        // a fire event goes out one pass late, once we know if it is the last
                        if (pend_valid_reg)
                        begin
                            reply_valid_next = 1'b1;
                            reply_kind_next  = tss_pkg::KIND_TICK;
                            reply_id_next    = pend_id_reg;
                            ok_next          = 1'b1;
                            reply_count_next = pend_count_reg;
                            reply_fire_next  = pend_fire_reg;
                            reply_last_next  = !scan_flags.best_found;
                        end
                        if (scan_flags.best_found)
                        begin
                            done_next[best_idx] = 1'b1;
                            fire_next           = fire_inc;
                            if (best_periodic)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = best_idx;
                                ram_wdata = {best_ident, 1'b1, best_interval,
                                             now_reg + TIME_BITS'(best_interval)};
                            end
                            else
                            begin
                                valid_next[best_idx] = 1'b0;
                                cnt_after            = count_reg - CNT_W'(1);
                            end
                            count_next      = cnt_after;
                            pend_valid_next = 1'b1;
                            pend_id_next    = best_ident;
                            pend_count_next = cnt_after;
                            pend_fire_next  = fire_inc;
                            nres_next       = nres_reg + RES_W'(1);
                            cnt_next        = '0;
                            if (nres_reg == RES_W'(tss_pkg::MAX_RESULTS - 1))
                            begin
                                state_next = S_FLUSH;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        else
                        begin
                            pend_valid_next = 1'b0;
                            state_next      = S_IDLE;
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_FLUSH:
            begin
                reply_valid_next = 1'b1;
                reply_kind_next  = tss_pkg::KIND_TICK;
                reply_id_next    = pend_id_reg;
                ok_next          = 1'b1;
                reply_count_next = pend_count_reg;
                reply_fire_next  = pend_fire_reg;
                reply_last_next  = 1'b1;
                pend_valid_next  = 1'b0;
                state_next       = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            op_reg          <= tss_pkg::KIND_ADD;
            now_reg         <= '0;
            next_id_reg     <= tss_pkg::ID_W'(1);
            fire_reg        <= '0;
            count_reg       <= '0;
            valid_reg       <= '0;
            done_reg        <= '0;
            max_active_reg  <= tss_pkg::MAX_ACTIVE_RST;
            nres_reg        <= '0;
            pend_valid_reg  <= 1'b0;
            rd_valid_reg    <= 1'b0;
            reply_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            op_reg          <= op_next;
            now_reg         <= now_next;
            next_id_reg     <= next_id_next;
            fire_reg        <= fire_next;
            count_reg       <= count_next;
            valid_reg       <= valid_next;
            done_reg        <= done_next;
            max_active_reg  <= max_active_next;
            nres_reg        <= nres_next;
            pend_valid_reg  <= pend_valid_next;
            rd_valid_reg    <= rd_valid_next;
            reply_valid_reg <= reply_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        delay_reg       <= delay_next;
        interval_reg    <= interval_next;
        periodic_reg    <= periodic_next;
        pend_id_reg     <= pend_id_next;
        pend_count_reg  <= pend_count_next;
        pend_fire_reg   <= pend_fire_next;
        rd_idx_reg      <= rd_idx_next;
        reply_kind_reg  <= reply_kind_next;
        reply_id_reg    <= reply_id_next;
        ok_reg          <= ok_next;
        reply_count_reg <= reply_count_next;
        reply_fire_reg  <= reply_fire_next;
        reply_last_reg  <= reply_last_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign reply_valid  = reply_valid_reg;
    assign reply_kind   = reply_kind_reg;
    assign reply_id     = reply_id_reg;
    assign ok           = ok_reg;
    assign active_count = tss_pkg::ACT_W'(reply_count_reg);
    assign fired_total  = reply_fire_reg;
    assign last         = reply_last_reg;

    `TSS_ASSERT_NEVER(a_count_tracks_valid, clk, rst_n, (count_reg != CNT_W'($countones(valid_reg))), "active count out of step with valid bits")
    `TSS_ASSERT(a_ok_has_id, clk, rst_n, (reply_valid_reg && ok_reg |-> (reply_id_reg != '0)), "successful reply carries id zero")
    `TSS_ASSERT(a_single_reply_last, clk, rst_n, (reply_valid_reg && (reply_kind_reg != tss_pkg::KIND_TICK) |-> reply_last_reg), "add or cancel reply not marked last")
    `TSS_ASSERT_NEVER(a_fire_cap, clk, rst_n, (nres_reg > RES_W'(tss_pkg::MAX_RESULTS)), "too many firings in one tick")

endmodule

[hw/rtl/tss_ram.sv]
// Generic single-write, single-read RAM with registered read data
module tss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/tss_scan.sv]
// Shared compare unit: evaluates one slot per cycle and keeps best, match and free
module tss_scan #(
    parameter int NUM_SLOTS = tss_pkg::NUM_SLOTS_DEF,
    parameter int TIME_BITS = tss_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tss_pkg::scan_ctl_t            ctl,
    input  logic [$clog2(NUM_SLOTS)-1:0]  idx,
    input  logic                          slot_valid,
    input  logic                          slot_done,
    input  logic [tss_pkg::ID_W-1:0]      rd_ident,
    input  logic                          rd_periodic,
    input  logic [tss_pkg::IVL_W-1:0]     rd_interval,
    input  logic [TIME_BITS-1:0]          rd_deadline,
    input  logic [TIME_BITS-1:0]          now,
    input  logic [tss_pkg::ID_W-1:0]      key,
    output tss_pkg::scan_flags_t          flags,
    output logic [$clog2(NUM_SLOTS)-1:0]  best_idx,
    output logic [tss_pkg::ID_W-1:0]      best_ident,
    output logic                          best_periodic,
    output logic [tss_pkg::IVL_W-1:0]     best_interval,
    output logic [$clog2(NUM_SLOTS)-1:0]  match_idx,
    output logic [$clog2(NUM_SLOTS)-1:0]  free_idx
);

    `include "timer_slot_scheduler_defines.svh"

    localparam int IDX_W = $clog2(NUM_SLOTS);

    // stage 1: lateness of the slot just read
    logic                      s2_valid_reg, s2_valid_next;
    logic [IDX_W-1:0]          s2_idx_reg, s2_idx_next;
    logic [TIME_BITS-1:0]      s2_late_reg, s2_late_next;
    logic [tss_pkg::ID_W-1:0]  s2_ident_reg, s2_ident_next;
    logic                      s2_periodic_reg, s2_periodic_next;
    logic [tss_pkg::IVL_W-1:0] s2_interval_reg, s2_interval_next;
    logic                      s2_cand_reg, s2_cand_next;
    logic                      s2_match_reg, s2_match_next;
    logic                      s2_free_reg, s2_free_next;

    // stage 2: running best, first match, first free
    tss_pkg::scan_flags_t      flags_reg, flags_next;
    logic [IDX_W-1:0]          best_idx_reg, best_idx_next;
    logic [TIME_BITS-1:0]      best_late_reg, best_late_next;
    logic [tss_pkg::ID_W-1:0]  best_ident_reg, best_ident_next;
    logic                      best_periodic_reg, best_periodic_next;
    logic [tss_pkg::IVL_W-1:0] best_interval_reg, best_interval_next;
    logic [IDX_W-1:0]          match_idx_reg, match_idx_next;
    logic [IDX_W-1:0]          free_idx_reg, free_idx_next;
    logic                      better;

    always_comb
    begin
        s2_valid_next    = ctl.load;
        s2_idx_next      = idx;
        s2_late_next     = now - rd_deadline;
        s2_ident_next    = rd_ident;
        s2_periodic_next = rd_periodic;
        s2_interval_next = rd_interval;
        // due when lateness lies in the lower half of the time range
        s2_cand_next     = slot_valid && !slot_done && !s2_late_next[TIME_BITS-1];
        s2_match_next    = slot_valid && (rd_ident == key);
        s2_free_next     = !slot_valid;
    end

    always_comb
    begin
        flags_next         = flags_reg;
        best_idx_next      = best_idx_reg;
        best_late_next     = best_late_reg;
        best_ident_next    = best_ident_reg;
        best_periodic_next = best_periodic_reg;
        best_interval_next = best_interval_reg;
        match_idx_next     = match_idx_reg;
        free_idx_next      = free_idx_reg;

        // most late first, ties to the lower id
        better = !flags_reg.best_found || (s2_late_reg > best_late_reg) ||
                 ((s2_late_reg == best_late_reg) && (s2_ident_reg < best_ident_reg));

        if (ctl.clear)
        begin
            flags_next = '0;
        end
        else if (s2_valid_reg)
        begin
            if (s2_cand_reg && better)
            begin
                flags_next.best_found = 1'b1;
                best_idx_next         = s2_idx_reg;
                best_late_next        = s2_late_reg;
                best_ident_next       = s2_ident_reg;
                best_periodic_next    = s2_periodic_reg;
                best_interval_next    = s2_interval_reg;
            end
            if (s2_match_reg && !flags_reg.match_found)
            begin
                flags_next.match_found = 1'b1;
                match_idx_next         = s2_idx_reg;
            end
            if (s2_free_reg && !flags_reg.free_found)
            begin
                flags_next.free_found = 1'b1;
                free_idx_next         = s2_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            flags_reg    <= '0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            flags_reg    <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_idx_reg        <= s2_idx_next;
        s2_late_reg       <= s2_late_next;
        s2_ident_reg      <= s2_ident_next;
        s2_periodic_reg   <= s2_periodic_next;
        s2_interval_reg   <= s2_interval_next;
        s2_cand_reg       <= s2_cand_next;
        s2_match_reg      <= s2_match_next;
        s2_free_reg       <= s2_free_next;
        best_idx_reg      <= best_idx_next;
        best_late_reg     <= best_late_next;
        best_ident_reg    <= best_ident_next;
        best_periodic_reg <= best_periodic_next;
        best_interval_reg <= best_interval_next;
        match_idx_reg     <= match_idx_next;
        free_idx_reg      <= free_idx_next;
    end

    assign flags         = flags_reg;
    assign best_idx      = best_idx_reg;
    assign best_ident    = best_ident_reg;
    assign best_periodic = best_periodic_reg;
    assign best_interval = best_interval_reg;
    assign match_idx     = match_idx_reg;
    assign free_idx      = free_idx_reg;

    `TSS_ASSERT(a_best_is_due, clk, rst_n, (flags_reg.best_found |-> !best_late_reg[TIME_BITS-1]), "best timer is not due")
    `TSS_ASSERT(a_clear_empties, clk, rst_n, (ctl.clear && !ctl.load |=> (flags_reg == '0)), "pass did not start empty")
    `TSS_ASSERT_NEVER(a_match_not_free, clk, rst_n, (s2_valid_reg && s2_match_reg && s2_free_reg), "slot both matched and free")

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the timer slot scheduler: directed and random commands
module tb_top;
    import tss_pkg::*;

    localparam int SLOTS          = NUM_SLOTS_DEF;
    localparam int PASS_CYCLES    = SLOTS + 3;
    localparam int SETTLE_CYCLES  = 2 * PASS_CYCLES;
    localparam int RAND_PER_PHASE = 21;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic              ok;
        logic [ACT_W-1:0]  act;
        logic [FIRE_W-1:0] fired;
        logic              last;
    } sched_reply_t;

    class sched_scoreboard;
        logic [TIME_BITS_DEF-1:0] now_tick    = '0;
        bit                       slot_live   [SLOTS];
        logic [TIME_BITS_DEF-1:0] slot_due    [SLOTS];
        logic [IVL_W-1:0]         slot_reload [SLOTS];
        bit                       slot_repeat [SLOTS];
        logic [ID_W-1:0]          slot_id     [SLOTS];
        logic [ID_W-1:0]          next_id     = 16'd1;
        logic [FIRE_W-1:0]        fire_cnt    = '0;
        logic [CFG_W-1:0]         max_active  = MAX_ACTIVE_RST;
        sched_reply_t             replies_due [$];
        int errors     = 0;
        int n_cmds     = 0;
        int n_fired    = 0;
        int n_refused  = 0;
        int peak_burst = 0;

        function int live_count();
            int n = 0;
            foreach (slot_live[i])
                if (slot_live[i])
                    n++;
            return n;
        endfunction

        function logic [ID_W-1:0] upcoming_id();
            return (next_id == '0) ? 16'd1 : next_id;
        endfunction

        function logic [ID_W-1:0] pick_live_id();
            int picks [$];
            foreach (slot_live[i])
                if (slot_live[i])
                    picks.push_back(i);
            if (picks.size() == 0)
                return '0;
            return slot_id[picks[$urandom_range(picks.size() - 1)]];
        endfunction

        function void push_reply(logic [KIND_W-1:0] k, logic [ID_W-1:0] id, logic good,
                                 logic fin);
            sched_reply_t r;
            r.kind  = k;
            r.id    = id;
            r.ok    = good;
            r.act   = ACT_W'(live_count());
            r.fired = fire_cnt;
            r.last  = fin;
            replies_due.push_back(r);
        endfunction

        function void set_limit(logic [CFG_W-1:0] v);
            max_active = v;
        endfunction

        // one accepted command transaction: update state, queue the replies it causes
        function void note_command(logic [KIND_W-1:0] k, logic [DLY_W-1:0] dly,
                                   logic [IVL_W-1:0] ivl, logic per, logic [ID_W-1:0] tgt);
            logic [ID_W-1:0]          id;
            logic [TIME_BITS_DEF-1:0] late;
            logic [TIME_BITS_DEF-1:0] best_late;
            int  limit;
            int  hit;
            int  best;
            int  burst;
            bit  in_use;
            bit  scanning;
            bit  fired_now [SLOTS];
            if (k != KIND_UNUSED)
                n_cmds++;
            case (k)
                KIND_ADD:
                begin
                    // id is consumed even when the add is refused
                    id      = upcoming_id();
                    next_id = id + 16'd1;
                    limit   = (int'(max_active) < SLOTS) ? int'(max_active) : SLOTS;
                    in_use  = 1'b0;
                    hit     = -1;
                    foreach (slot_live[i])
                    begin
                        if (slot_live[i] && slot_id[i] == id)
                            in_use = 1'b1;
                        if (!slot_live[i] && hit < 0)
                            hit = i;
                    end
                    if (in_use || live_count() >= limit || hit < 0)
                    begin
                        n_refused++;
                        push_reply(KIND_ADD, '0, 1'b0, 1'b1);
                    end
                    else
                    begin
                        slot_live[hit]   = 1'b1;
                        slot_id[hit]     = id;
                        slot_due[hit]    = now_tick + TIME_BITS_DEF'(dly);
                        slot_reload[hit] = ivl;
                        slot_repeat[hit] = per;
                        push_reply(KIND_ADD, id, 1'b1, 1'b1);
                    end
                end
                KIND_CANCEL:
                begin
                    hit = -1;
                    if (tgt != '0)
                        foreach (slot_live[i])
                            if (slot_live[i] && slot_id[i] == tgt && hit < 0)
                                hit = i;
                    if (hit >= 0)
                    begin
                        slot_live[hit] = 1'b0;
                        push_reply(KIND_CANCEL, tgt, 1'b1, 1'b1);
                    end
                    else
                        push_reply(KIND_CANCEL, '0, 1'b0, 1'b1);
                end
                KIND_TICK:
                begin
                    now_tick = now_tick + TIME_BITS_DEF'(1);
                    foreach (fired_now[i])
                        fired_now[i] = 1'b0;
                    burst    = 0;
                    scanning = 1'b1;
                    while (scanning && burst < MAX_RESULTS)
                    begin
                        best      = -1;
                        best_late = '0;
                        foreach (slot_live[i])
                        begin
                            // due when the wrapped distance past the deadline is non-negative
                            late = now_tick - slot_due[i];
                            if (slot_live[i] && !fired_now[i] && !late[TIME_BITS_DEF-1] &&
                                (best < 0 || late > best_late ||
                                 (late == best_late && slot_id[i] < slot_id[best])))
                            begin
                                best      = i;
                                best_late = late;
                            end
                        end
                        if (best < 0)
                            scanning = 1'b0;
                        else
                        begin
                            fired_now[best] = 1'b1;
                            fire_cnt        = fire_cnt + FIRE_W'(1);
                            n_fired++;
                            if (slot_repeat[best])
                                slot_due[best] = now_tick + TIME_BITS_DEF'(slot_reload[best]);
                            else
                                slot_live[best] = 1'b0;
                            if (burst > 0)
                                replies_due[replies_due.size() - 1].last = 1'b0;
                            push_reply(KIND_TICK, slot_id[best], 1'b1, 1'b1);
                            burst++;
                        end
                    end
                    if (burst > peak_burst)
                        peak_burst = burst;
                end
                default: ;
            endcase
        endfunction

        function void cmp(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, want,
                         got);
            end
        endfunction

        function void check_reply(logic [KIND_W-1:0] k, logic [ID_W-1:0] id, logic good,
                                  logic [ACT_W-1:0] act, logic [FIRE_W-1:0] fired, logic fin);
            sched_reply_t want;
            if (replies_due.size() == 0)
            begin
                errors++;
                $display("%0t ns: reply with none pending, expected nothing actual kind %0d id %0d",
                         $time, k, id);
                return;
            end
            want = replies_due.pop_front();
            cmp("reply_kind", 32'(want.kind), 32'(k));
            cmp("reply_id", 32'(want.id), 32'(id));
            cmp("ok", 32'(want.ok), 32'(good));
            cmp("active_count", 32'(want.act), 32'(act));
            cmp("fired_total", want.fired, fired);
            cmp("last", 32'(want.last), 32'(fin));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [KIND_W-1:0] kind;
    logic [DLY_W-1:0]  delay_ticks;
    logic [IVL_W-1:0]  interval_ticks;
    logic              periodic;
    logic [ID_W-1:0]   target_id;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data;
    logic              reply_valid;
    logic [KIND_W-1:0] reply_kind;
    logic [ID_W-1:0]   reply_id;
    logic              ok;
    logic [ACT_W-1:0]  active_count;
    logic [FIRE_W-1:0] fired_total;
    logic              last;

    sched_scoreboard sb = new;
    bit steady = 1'b0;

    timer_slot_scheduler u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .delay_ticks    (delay_ticks),
        .interval_ticks (interval_ticks),
        .periodic       (periodic),
        .target_id      (target_id),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .reply_valid    (reply_valid),
        .reply_kind     (reply_kind),
        .reply_id       (reply_id),
        .ok             (ok),
        .active_count   (active_count),
        .fired_total    (fired_total),
        .last           (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // replies are checked before a command accepted on the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (reply_valid)
                sb.check_reply(reply_kind, reply_id, ok, active_count, fired_total, last);
            if (start && !busy)
                sb.note_command(kind, delay_ticks, interval_ticks, periodic, target_id);
            if (cfg_valid && cfg_ready)
                sb.set_limit(cfg_data);
        end
    end

    // start stays high on return; the caller either sends again or lowers it
    task automatic send_cmd(input logic [KIND_W-1:0] k, input logic [DLY_W-1:0] dly,
                            input logic [IVL_W-1:0] ivl, input logic per,
                            input logic [ID_W-1:0] tgt);
        start          <= 1'b1;
        kind           <= k;
        delay_ticks    <= dly;
        interval_ticks <= ivl;
        periodic       <= per;
        target_id      <= tgt;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic pause_cmd(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic maybe_idle();
        if (!steady && $urandom_range(99) < 35)
            pause_cmd($urandom_range(1, 30));
    endtask

    // an idle tick gives no reply, so settle for a couple of table passes
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (sb.replies_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic cancel_all();
        logic [ID_W-1:0] doomed [$];
        wait_drained();
        foreach (sb.slot_live[i])
            if (sb.slot_live[i])
                doomed.push_back(sb.slot_id[i]);
        foreach (doomed[j])
            send_cmd(KIND_CANCEL, '0, '0, 1'b0, doomed[j]);
    endtask

    task automatic random_cmd(output bit counted);
        logic [KIND_W-1:0] k;
        logic [DLY_W-1:0]  dly;
        logic [IVL_W-1:0]  ivl;
        logic [ID_W-1:0]   tgt;
        int r;
        r   = $urandom_range(99);
        dly = ($urandom_range(11) == 0) ? DLY_W'($urandom) : DLY_W'($urandom_range(0, 6));
        ivl = ($urandom_range(11) == 0) ? IVL_W'($urandom) : IVL_W'($urandom_range(0, 5));
        tgt = ID_W'($urandom);
        if (r < 38)
            k = KIND_ADD;
        else if (r < 60)
        begin
            k = KIND_CANCEL;
            r = $urandom_range(9);
            if (r == 0)
                tgt = '0;
            else if (r > 1)
                tgt = sb.pick_live_id();
        end
        else if (r < 97)
            k = KIND_TICK;
        else
            k = KIND_UNUSED;
        send_cmd(k, dly, ivl, 1'($urandom_range(1)), tgt);
        counted = (k != KIND_UNUSED);
    endtask

    initial
    begin
        logic [CFG_W-1:0] phase_limit [4];
        int  done;
        bit  counted;
        rst_n          = 1'b0;
        start          = 1'b0;
        kind           = KIND_ADD;
        delay_ticks    = '0;
        interval_ticks = '0;
        periodic       = 1'b0;
        target_id      = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero delay, zero interval, extremes of the add fields
        send_cmd(KIND_ADD, '0, '0, 1'b1, '0);
        send_cmd(KIND_ADD, '0, '1, 1'b0, '0);
        send_cmd(KIND_ADD, '1, '1, 1'b1, '1);
        send_cmd(KIND_TICK, '0, '0, 1'b0, '0);
        // tie on lateness goes to the lower id, later deadline last
        send_cmd(KIND_ADD, 20'd1, 20'd2, 1'b1, '0);
        send_cmd(KIND_ADD, '0, '0, 1'b0, '0);
        send_cmd(KIND_TICK, '1, '1, 1'b1, '1);
        send_cmd(KIND_CANCEL, '1, '1, 1'b1, 16'd1);
        send_cmd(KIND_CANCEL, '0, '0, 1'b0, 16'd1);
        send_cmd(KIND_CANCEL, '1, '1, 1'b1, '0);
        send_cmd(KIND_CANCEL, '0, '0, 1'b0, '1);
        send_cmd(KIND_TICK, '0, '0, 1'b0, '0);
        send_cmd(KIND_UNUSED, '1, '1, 1'b1, '1);
        write_limit(5'd0);
        send_cmd(KIND_ADD, 20'd3, 20'd3, 1'b0, '0);
        cancel_all();
        // fill every slot, overflow once, then fire all sixteen on one tick
        write_limit(5'd31);
        repeat (SLOTS + 1)
            send_cmd(KIND_ADD, 20'd1, '0, 1'($urandom_range(1)), '0);
        send_cmd(KIND_TICK, '0, '0, 1'b0, '0);
        send_cmd(KIND_TICK, '0, '0, 1'b0, '0);
        cancel_all();

        phase_limit[0] = CFG_W'($urandom_range(1, 15));
        phase_limit[1] = 5'd16;
        phase_limit[2] = 5'd17;
        phase_limit[3] = CFG_W'($urandom_range(1, 4));
        for (int p = 0; p < 4; p++)
        begin
            write_limit(phase_limit[p]);
            steady = (p == 1);
            done   = 0;
            while (done < RAND_PER_PHASE)
            begin
                random_cmd(counted);
                if (counted)
                    done++;
                if ($urandom_range(99) < 4)
                    wait_drained();
                else
                    maybe_idle();
            end
        end
        steady = 1'b0;

        wait_drained();
        $display("Covered %0d commands, %0d timer firings (up to %0d per tick), %0d refused adds,",
                 sb.n_cmds, sb.n_fired, sb.peak_burst, sb.n_refused);
        $display("with max_active swept from 0 to 31 and a completely full slot table.");
        if (sb.errors == 0)
            $display("** timer_slot_scheduler: PASSED **");
        else
            $display("** timer_slot_scheduler: FAILED **");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout: replies still pending: %0d", sb.replies_due.size());
        $display("** timer_slot_scheduler: FAILED **");
        $finish;
    end
endmodule
